// ----- sv/operand_value_decoder_macros.svh -----
// Assertion macros used by the bound checker in ovd_checker.sv.
`ifndef OPERAND_VALUE_DECODER_MACROS_SVH
`define OPERAND_VALUE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define OVD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define OVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ovd_pkg.sv -----
package ovd_pkg;

  localparam int TARGET_ENTRIES = 8192;
  localparam int IDX_W = $clog2(TARGET_ENTRIES);
  localparam int CNT_W = $clog2(TARGET_ENTRIES + 1);

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int LEN_W = 3;
  localparam int STATUS_W = 3;
  localparam int VALUE_W = 36;
  localparam int ADDR_W = 32;
  localparam int TCNT_W = 14;
  localparam int BP_W = 6;
  localparam int BL_W = 3;
  localparam int MAX_VAR_BYTES = 5;
  localparam int VAR_BITS = 4;

  localparam int Q_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_BYTE  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_t;

  typedef enum logic [LEN_W-1:0] {
    LEN_VAR = 3'd0,
    LEN_1   = 3'd1,
    LEN_2   = 3'd2,
    LEN_4   = 3'd4
  } len_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MORE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_ZERO     = 3'd3,
    ST_ADDR_BIG = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CMD_RESULT = 3'b001,
    CMD_SEARCH = 3'b010,
    CMD_CLEAR  = 3'b100
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic                 flag;
  } ovd_entry_t;

endpackage

// ----- sv/ovd_in_if.sv -----
interface ovd_in_if import ovd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  length_code;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, op, kind, length_code, data_byte, input ready);
  modport sink (input valid, op, kind, length_code, data_byte, output ready);
endinterface

// ----- sv/ovd_out_if.sv -----
interface ovd_out_if import ovd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value;
  logic                sign_flag;
  logic                target_added;
  logic [TCNT_W-1:0]   target_count;

  modport source (output valid, status, value, sign_flag, target_added, target_count,
                  input ready);
  modport sink (input valid, status, value, sign_flag, target_added, target_count,
                output ready);
endinterface

// ----- sv/ovd_cfg_if.sv -----
interface ovd_cfg_if import ovd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- sv/ovd_ram.sv -----
module ovd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ovd_front.sv -----
module ovd_front import ovd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ovd_in_if.sink        operand,
  ovd_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          push,
  output ovd_entry_t    push_entry
);

  logic [ADDR_W-1:0]  scenario_size;
  logic [VALUE_W-1:0] partial_value;
  logic [BP_W-1:0]    bit_position;
  logic [BL_W-1:0]    bytes_left;
  logic               latched_flag;
  kind_t              latched_kind;

  logic [VALUE_W-1:0] partial_value_next;
  logic [BP_W-1:0]    bit_position_next;
  logic [BL_W-1:0]    bytes_left_next;
  logic               latched_flag_next;
  kind_t              latched_kind_next;
  logic               commit;

  assign cfg.ready = 1'b1;
  assign operand.ready = !q_full;
  assign push = operand.valid && !q_full;

  always_comb begin
    logic [BL_W-1:0] cnt;
    logic            bad;
    cnt = operand.data_byte[6:4];
    bad = 1'b0;
    partial_value_next = partial_value;
    bit_position_next = bit_position;
    bytes_left_next = bytes_left;
    latched_flag_next = latched_flag;
    latched_kind_next = latched_kind;
    commit = 1'b0;
    push_entry.cmd = CMD_RESULT;
    push_entry.status = ST_MORE;
    push_entry.value = '0;
    push_entry.flag = 1'b0;

    if (operand.op == OP_CLEAR) begin
      push_entry.cmd = CMD_CLEAR;
      push_entry.status = ST_DONE;
    end else begin
      if (bit_position == '0) begin
        if (operand.length_code == LEN_VAR) begin
          if (cnt == '0 || cnt > BL_W'(MAX_VAR_BYTES)) begin
            bad = 1'b1;
          end else begin
            bytes_left_next = cnt;
            latched_flag_next = operand.data_byte[7];
            partial_value_next = VALUE_W'(operand.data_byte[VAR_BITS-1:0]);
            bit_position_next = BP_W'(VAR_BITS);
          end
        end else if (operand.length_code inside {LEN_1, LEN_2, LEN_4}) begin
          bytes_left_next = BL_W'(operand.length_code);
          latched_flag_next = 1'b0;
          partial_value_next = VALUE_W'(operand.data_byte);
          bit_position_next = BP_W'(BYTE_W);
        end else begin
          bad = 1'b1;
        end
        case (operand.kind)
          KIND_ADDR:  latched_kind_next = KIND_ADDR;
          KIND_COUNT: latched_kind_next = KIND_COUNT;
          default:    latched_kind_next = KIND_PLAIN;
        endcase
      end else begin
        if (bit_position < BP_W'(VALUE_W)) begin
          partial_value_next = partial_value | (VALUE_W'(operand.data_byte) << bit_position);
        end
        bit_position_next = bit_position + BP_W'(BYTE_W);
      end

      if (bad) begin
        push_entry.status = ST_BAD_LEN;
      end else begin
        commit = 1'b1;
        bytes_left_next = bytes_left_next - BL_W'(1);
        push_entry.value = partial_value_next;
        push_entry.flag = latched_flag_next;
        if (bytes_left_next != '0) begin
          push_entry.status = ST_MORE;
        end else begin
          bit_position_next = '0;
          if (latched_kind_next == KIND_COUNT && partial_value_next == '0) begin
            push_entry.status = ST_ZERO;
          end else if (latched_kind_next == KIND_ADDR) begin
            if (partial_value_next >= VALUE_W'(scenario_size)) begin
              push_entry.status = ST_ADDR_BIG;
            end else begin
              push_entry.cmd = CMD_SEARCH;
              push_entry.status = ST_DONE;
            end
          end else begin
            push_entry.status = ST_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scenario_size <= '0;
      partial_value <= '0;
      bit_position <= '0;
      bytes_left <= '0;
      latched_flag <= 1'b0;
      latched_kind <= KIND_PLAIN;
    end else begin
      if (cfg.valid) begin
        scenario_size <= cfg.data;
      end
      if (push && commit) begin
        partial_value <= partial_value_next;
        bit_position <= bit_position_next;
        bytes_left <= bytes_left_next;
        latched_flag <= latched_flag_next;
        latched_kind <= latched_kind_next;
      end
    end
  end

endmodule

// ----- sv/ovd_queue.sv -----
module ovd_queue import ovd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ovd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output ovd_entry_t pop_entry,
  output logic       empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  ovd_entry_t        slots [Q_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [QCNT_W-1:0] fill;

  assign full = fill == QCNT_W'(Q_DEPTH);
  assign empty = fill == '0;
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- sv/ovd_back.sv -----
module ovd_back import ovd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  ovd_entry_t q_entry,
  output logic       pop,
  ovd_out_if.source  result
);

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_SEARCH = 3'b010,
    B_FINISH = 3'b100
  } back_state_t;

  back_state_t         state;
  back_state_t         state_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    rd_idx_next;
  logic                cmp_pend;
  logic                cmp_pend_next;
  logic [VALUE_W-1:0]  key;
  logic                key_flag;
  status_t             fin_status;
  status_t             fin_status_next;
  logic                fin_add;
  logic                fin_add_next;

  logic                out_valid;
  status_t             out_status;
  logic [VALUE_W-1:0]  out_value;
  logic                out_flag;
  logic                out_added;
  logic [CNT_W-1:0]    out_count;
  logic [CNT_W+TCNT_W-1:0] out_count_wide;

  logic                load;
  status_t             load_status;
  logic [VALUE_W-1:0]  load_value;
  logic                load_flag;
  logic                load_added;

  logic                out_free;
  logic                re;
  logic                we;
  logic [ADDR_W-1:0]   rdata;
  logic                hit;

  assign out_free = !out_valid || result.ready;
  assign hit = cmp_pend && (rdata == key[ADDR_W-1:0]);

  ovd_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TARGET_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata (key[ADDR_W-1:0]),
    .re    (re),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    rd_idx_next = rd_idx;
    cmp_pend_next = cmp_pend;
    fin_status_next = fin_status;
    fin_add_next = fin_add;
    pop = 1'b0;
    re = 1'b0;
    we = 1'b0;
    load = 1'b0;
    load_status = q_entry.status;
    load_value = q_entry.value;
    load_flag = q_entry.flag;
    load_added = 1'b0;

    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_entry.cmd == CMD_SEARCH) begin
            pop = 1'b1;
            rd_idx_next = '0;
            cmp_pend_next = 1'b0;
            state_next = B_SEARCH;
          end else if (out_free) begin
            pop = 1'b1;
            load = 1'b1;
            if (q_entry.cmd == CMD_CLEAR) begin
              count_next = '0;
              load_status = ST_DONE;
              load_value = '0;
              load_flag = 1'b0;
            end
          end
        end
      end
      B_SEARCH: begin
        if (hit) begin
          fin_status_next = ST_DONE;
          fin_add_next = 1'b0;
          state_next = B_FINISH;
        end else if (rd_idx != count) begin
          re = 1'b1;
          rd_idx_next = rd_idx + CNT_W'(1);
          cmp_pend_next = 1'b1;
        end else begin
          fin_add_next = count != CNT_W'(TARGET_ENTRIES);
          fin_status_next = fin_add_next ? ST_DONE : ST_FULL;
          state_next = B_FINISH;
        end
      end
      B_FINISH: begin
        if (out_free) begin
          load = 1'b1;
          load_status = fin_status;
          load_value = key;
          load_flag = key_flag;
          load_added = fin_add;
          if (fin_add) begin
            we = 1'b1;
            count_next = count + CNT_W'(1);
          end
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
      rd_idx <= '0;
      cmp_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_idx <= rd_idx_next;
      cmp_pend <= cmp_pend_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_status <= fin_status_next;
    fin_add <= fin_add_next;
    if (pop && q_entry.cmd == CMD_SEARCH) begin
      key <= q_entry.value;
      key_flag <= q_entry.flag;
    end
    if (load) begin
      out_status <= load_status;
      out_value <= load_value;
      out_flag <= load_flag;
      out_added <= load_added;
      out_count <= count_next;
    end
  end

  assign out_count_wide = {{TCNT_W{1'b0}}, out_count};

  assign result.valid = out_valid;
  assign result.status = out_status;
  assign result.value = out_value;
  assign result.sign_flag = out_flag;
  assign result.target_added = out_added;
  assign result.target_count = out_count_wide[TCNT_W-1:0];

endmodule

// ----- sv/operand_value_decoder.sv -----
// Channel   Role    Payload
// operand   sink    op, kind, length_code, data_byte
// result    source  status, value, sign_flag, target_added, target_count
// cfg       sink    data (scenario size)
//
// Every request is taken in the cycle it is offered while the internal queue has room.
// A finished address below the scenario size searches the jump target table through its
// single read port, ending on a hit or after the last stored target; every other request
// goes straight from the queue into the output register once that register is free.
// Reset clears the control state; the target table itself is not cleared.
// Either side may stall on its own; the queue and the output register decouple them.
module operand_value_decoder import ovd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ovd_in_if.sink     operand,
  ovd_out_if.source  result,
  ovd_cfg_if.sink    cfg
);

  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  ovd_entry_t push_entry;
  ovd_entry_t pop_entry;

  ovd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .operand    (operand),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ovd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  ovd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ----- sv/ovd_checker.sv -----
`include "operand_value_decoder_macros.svh"

module ovd_checker import ovd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [VALUE_W-1:0]  out_value,
  input logic                out_sign_flag,
  input logic                out_added,
  input logic [TCNT_W-1:0]   out_count
);

  `OVD_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status), "Stalled result changed or vanished.")
  `OVD_ASSERT_NOW(a_added_done, out_valid && out_added, out_status == ST_DONE && out_count != '0, "A new target was reported without a done status or a stored count.")
  `OVD_ASSERT_NOW(a_bad_len_clean, out_valid && out_status == ST_BAD_LEN, out_value == '0 && !out_sign_flag && !out_added, "A bad length result carries a value or flags.")
  `OVD_ASSERT_NOW(a_quiet_after_reset, $past(rst), !out_valid, "A result appeared right after reset.")

endmodule

bind operand_value_decoder ovd_checker u_ovd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_status    (result.status),
  .out_value     (result.value),
  .out_sign_flag (result.sign_flag),
  .out_added     (result.target_added),
  .out_count     (result.target_count)
);

// ----- sim/operand_decode_checker.sv -----
`timescale 1ns / 1ps

module operand_decode_checker import ovd_pkg::*; (
  input  logic clk,
  input  logic rst,
  ovd_in_if    operand,
  ovd_out_if   result,
  ovd_cfg_if   cfg,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   targets_added
);

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value;
    logic                flag;
    logic                added;
    logic [TCNT_W-1:0]   count;
  } decode_result_t;

  logic [ADDR_W-1:0]  scen_size;
  logic [VALUE_W-1:0] acc_value;
  int                 acc_shift;
  int                 bytes_remaining;
  logic               held_flag;
  kind_t              held_kind;
  logic [ADDR_W-1:0]  jump_targets [TARGET_ENTRIES];
  int                 target_total;

  decode_result_t     decoded_queue[$];
  decode_result_t     want;
  decode_result_t     got;

  function automatic decode_result_t decode_operand(logic op, logic [KIND_W-1:0] k,
                                                    logic [LEN_W-1:0] lc,
                                                    logic [BYTE_W-1:0] b);
    decode_result_t r;
    int cnt;
    logic [VALUE_W-1:0] v;
    bit seen;
    r = '0;
    r.count = TCNT_W'(target_total);
    if (op == OP_CLEAR) begin
      target_total = 0;
      r.status = ST_DONE;
      r.count = '0;
      return r;
    end
    if (acc_shift == 0) begin
      if (lc == LEN_VAR) begin
        cnt = int'(b[6:4]);
        if (cnt == 0 || cnt > MAX_VAR_BYTES) begin
          r.status = ST_BAD_LEN;
          return r;
        end
        bytes_remaining = cnt;
        held_flag = b[7];
        acc_value = VALUE_W'(b[VAR_BITS-1:0]);
        acc_shift = VAR_BITS;
      end else if (lc == LEN_1 || lc == LEN_2 || lc == LEN_4) begin
        bytes_remaining = int'(lc);
        held_flag = 1'b0;
        acc_value = VALUE_W'(b);
        acc_shift = BYTE_W;
      end else begin
        r.status = ST_BAD_LEN;
        return r;
      end
      held_kind = (k == 2'd3) ? KIND_PLAIN : kind_t'(k);
    end else begin
      if (acc_shift < VALUE_W) acc_value = acc_value | (VALUE_W'(b) << acc_shift);
      acc_shift = (acc_shift + BYTE_W) % 64;
    end
    bytes_remaining = (bytes_remaining - 1) & 7;
    r.value = acc_value;
    r.flag = held_flag;
    if (bytes_remaining != 0) begin
      r.status = ST_MORE;
      return r;
    end
    acc_shift = 0;
    v = acc_value;
    r.status = ST_DONE;
    if (held_kind == KIND_COUNT && v == 0) begin
      r.status = ST_ZERO;
    end else if (held_kind == KIND_ADDR) begin
      if (v >= VALUE_W'(scen_size)) begin
        r.status = ST_ADDR_BIG;
      end else begin
        seen = 0;
        for (int i = 0; i < target_total; i++) begin
          if (jump_targets[i] == v[ADDR_W-1:0]) seen = 1;
        end
        if (!seen) begin
          if (target_total >= TARGET_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            jump_targets[target_total] = v[ADDR_W-1:0];
            target_total++;
            r.added = 1'b1;
            r.count = TCNT_W'(target_total);
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decoded_queue.delete();
      scen_size = '0;
      acc_value = '0;
      acc_shift = 0;
      bytes_remaining = 0;
      held_flag = 1'b0;
      held_kind = KIND_PLAIN;
      target_total = 0;
    end else begin
      if (cfg.valid && cfg.ready) scen_size = cfg.data;
      if (operand.valid && operand.ready) begin
        decoded_queue.push_back(decode_operand(operand.op, operand.kind,
                                               operand.length_code, operand.data_byte));
      end
      if (result.valid && result.ready) begin
        got.status = status_t'(result.status);
        got.value = result.value;
        got.flag = result.sign_flag;
        got.added = result.target_added;
        got.count = result.target_count;
        if (decoded_queue.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0d value 0x%0h",
                   $time, got.status, got.value);
        end else begin
          want = decoded_queue.pop_front();
          checked++;
          if (want.added) targets_added++;
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("value", 64'(want.value), 64'(got.value));
          check_field("sign_flag", 64'(want.flag), 64'(got.flag));
          check_field("target_added", 64'(want.added), 64'(got.added));
          check_field("target_count", 64'(want.count), 64'(got.count));
        end
      end
    end
    pending = decoded_queue.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ovd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;

  ovd_in_if  operand_ch();
  ovd_out_if result_ch();
  ovd_cfg_if cfg_ch();

  int errors;
  int pending;
  int checked;
  int targets_added;

  int  cycle_count;
  int  sent;
  int  configs;
  bit  no_idle;
  bit  hold_request;
  bit  operand_busy;
  logic [ADDR_W-1:0] cur_size;
  logic [ADDR_W-1:0] phase_sizes [5];
  int  bad_codes [4] = '{3, 5, 6, 7};

  operand_value_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  operand_decode_checker chk (
    .clk           (clk),
    .rst           (rst),
    .operand       (operand_ch),
    .result        (result_ch),
    .cfg           (cfg_ch),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .targets_added (targets_added)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run timed out after %0d cycles with %0d requests pending", cycle_count, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic put_request(logic op, logic [KIND_W-1:0] k, logic [LEN_W-1:0] lc,
                             logic [BYTE_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      operand_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operand_ch.valid <= 1'b1;
    operand_ch.op <= op;
    operand_ch.kind <= k;
    operand_ch.length_code <= lc;
    operand_ch.data_byte <= b;
    operand_busy = 1;
    do @(posedge clk); while (!operand_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    if (operand_busy) begin
      operand_ch.valid <= 1'b0;
      operand_busy = 0;
    end
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_size(logic [ADDR_W-1:0] size);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_size = size;
    configs++;
  endtask

  task automatic send_value(logic [KIND_W-1:0] k, logic [LEN_W-1:0] lc, int cnt,
                            logic [VALUE_W-1:0] v, logic flag);
    int nbytes;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] chunk;
    if (lc == LEN_VAR) begin
      first = {flag, 3'(cnt), v[3:0]};
      nbytes = cnt;
    end else begin
      first = v[7:0];
      nbytes = int'(lc);
    end
    put_request(OP_BYTE, k, lc, first);
    for (int i = 1; i < nbytes; i++) begin
      if ($urandom_range(0, 33) == 0) begin
        put_request(OP_CLEAR, KIND_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
      end
      chunk = (lc == LEN_VAR) ? v[4 + 8 * (i - 1) +: 8] : v[8 * i +: 8];
      put_request(OP_BYTE, KIND_W'($urandom), LEN_W'($urandom), chunk);
    end
  endtask

  task automatic send_random();
    int pick;
    int cnt;
    int bits;
    logic [KIND_W-1:0] k;
    logic [LEN_W-1:0] lc;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      if ($urandom_range(0, 1) == 0) begin
        put_request(OP_BYTE, KIND_W'($urandom), 3'(bad_codes[$urandom_range(0, 3)]),
                    BYTE_W'($urandom));
      end else begin
        cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(6, 7);
        put_request(OP_BYTE, KIND_W'($urandom), LEN_VAR,
                    {1'($urandom), 3'(cnt), 4'($urandom)});
      end
    end else if (pick < 7) begin
      put_request(OP_CLEAR, KIND_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
    end else if (pick < 12) begin
      put_request(1'($urandom), KIND_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
    end else begin
      pick = $urandom_range(0, 9);
      k = (pick < 3) ? KIND_PLAIN : (pick < 7) ? KIND_ADDR : (pick < 9) ? KIND_COUNT
                                                                         : KIND_UNUSED;
      case ($urandom_range(0, 3))
        0: lc = LEN_VAR;
        1: lc = LEN_1;
        2: lc = LEN_2;
        default: lc = LEN_4;
      endcase
      cnt = $urandom_range(1, MAX_VAR_BYTES);
      bits = (lc == LEN_VAR) ? VAR_BITS + BYTE_W * (cnt - 1) : BYTE_W * int'(lc);
      pick = $urandom_range(0, 9);
      if (pick < 4) v = VALUE_W'($urandom_range(0, 40));
      else if (pick < 5) v = '0;
      else if (pick < 6) v = VALUE_W'(cur_size) - VALUE_W'($urandom_range(0, 1));
      else v = VALUE_W'({$urandom, $urandom});
      mask = (36'd1 << bits) - 36'd1;
      send_value(k, lc, cnt, v & mask, 1'($urandom));
    end
  endtask

  initial begin
    bit hold_done;
    hold_done = 0;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int wait_n;
      if (hold_request && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end
      wait_n = no_idle ? 0 : $urandom_range(0, 12);
      if (wait_n > 0) begin
        result_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int start;
    rst = 1'b1;
    operand_ch.valid = 1'b0;
    operand_ch.op = OP_BYTE;
    operand_ch.kind = KIND_PLAIN;
    operand_ch.length_code = LEN_1;
    operand_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    cur_size = '0;
    phase_sizes = '{32'hFFFF_FFFF, 32'd48, 32'd0, $urandom, 32'd1};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Scenario size still at its reset value, so any address is out of range.
    send_value(KIND_ADDR, LEN_1, 0, 36'd5, 1'b0);
    write_size(32'd100);
    put_request(OP_BYTE, KIND_PLAIN, LEN_VAR, 8'h0F);
    put_request(OP_BYTE, KIND_ADDR, LEN_VAR, 8'hE5);
    put_request(OP_BYTE, KIND_COUNT, LEN_VAR, 8'h7A);
    foreach (bad_codes[i]) put_request(OP_BYTE, KIND_PLAIN, 3'(bad_codes[i]), 8'hFF);
    send_value(KIND_PLAIN, LEN_VAR, MAX_VAR_BYTES, 36'hF_FFFF_FFFF, 1'b1);
    send_value(KIND_ADDR, LEN_1, 0, 36'd99, 1'b0);
    send_value(KIND_ADDR, LEN_2, 0, 36'd100, 1'b0);
    send_value(KIND_ADDR, LEN_VAR, 2, 36'd99, 1'b1);
    send_value(KIND_COUNT, LEN_1, 0, 36'd0, 1'b0);
    send_value(KIND_UNUSED, LEN_1, 0, 36'd0, 1'b0);
    put_request(OP_BYTE, KIND_ADDR, LEN_2, 8'h34);
    put_request(OP_CLEAR, KIND_PLAIN, LEN_VAR, 8'h00);
    put_request(OP_BYTE, KIND_PLAIN, LEN_VAR, 8'h00);

    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      no_idle = (p == 1);
      if (p == 2) hold_request = 1;
      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        if (p == 3 && sent - start == PHASE_ITEMS / 2) wait_drained();
        send_random();
      end
    end
    no_idle = 0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d operand requests over %0d scenario sizes.", sent, configs);
    $display("Checked %0d results, %0d of which stored a new jump target.",
             checked, targets_added);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
